// ===== hw/rtl/stepper_trapezoid_speed_ramp_unit_assert.svh =====
// Assertion macros for the stepper speed ramp unit.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef STEPPER_TRAPEZOID_SPEED_RAMP_UNIT_ASSERT_SVH
`define STEPPER_TRAPEZOID_SPEED_RAMP_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STSR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/stsr_pkg.sv =====
// Shared types and constants for the stepper speed ramp unit.
// No dependencies; the interfaces and every RTL module import this package.
`timescale 1ns / 1ps
`default_nettype none

package stsr_pkg;

    localparam int SPEED_W    = 24;
    localparam int INTERVAL_W = 16;
    localparam int PULSE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_N_W    = 32;
    localparam int DIV_D_W    = 24;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_INCREMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_INTERVAL  = 2'd2;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_PULSE = 1'b1;

    typedef struct packed {
        logic [SPEED_W-1:0]    start_speed;
        logic [SPEED_W-1:0]    accel_increment;
        logic [INTERVAL_W-1:0] accel_interval;
    } ramp_cfg_t;

    typedef struct packed {
        logic               action;
        logic [SPEED_W-1:0] set_speed;
        logic [PULSE_W-1:0] pulse_index;
        logic [PULSE_W-1:0] pulse_total;
    } cmd_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               start_status;
    } rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
        logic [DIV_D_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stsr_if.sv =====
// Channel interfaces of the stepper speed ramp unit: command, response, configuration.
// Depends on stsr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stsr_cmd_if import stsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [SPEED_W-1:0] set_speed;
    logic [PULSE_W-1:0] pulse_index;
    logic [PULSE_W-1:0] pulse_total;

    modport source (output valid, output action, output set_speed, output pulse_index,
                    output pulse_total, input ready);
    modport sink (input valid, input action, input set_speed, input pulse_index,
                  input pulse_total, output ready);
endinterface

interface stsr_rsp_if import stsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed;
    logic               start_status;

    modport source (output valid, output speed, output start_status, input ready);
    modport sink (input valid, input speed, input start_status, output ready);
endinterface

interface stsr_cfg_if import stsr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SPEED_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stepper_trapezoid_speed_ramp_unit.sv =====
// Top level of the stepper trapezoid speed ramp unit.
// Depends on stsr_pkg, the channel interfaces, stsr_ctrl, stsr_div and the assertion header.
//
// Usage: configuration registers (start speed, increment, interval) are written over the
// cfg channel, which is always ready; index 0, 1 and 2 select them, other indexes are
// ignored. Each command transaction on cmd is either a move start or a pulse query, and
// produces exactly one response transaction on rsp carrying the speed and a start status.
// A move start with a zero increment is rejected with start status 1.
// A command that needs no division passes the decide state, and for some pulses the classify
// state, before its result is handed on. A move start that computes its ramp length, and a
// pulse that falls in a ramp segment, run the shared 32-step restoring divider. The unit
// takes one command at a time, with cmd.ready low while a command is in work.
// The response sits in an output register, so a new command is accepted while the previous
// response still waits; if the receiver stalls, the next result is held in the sequencer
// until the output register frees up, and no response is lost or repeated.
// Reset (rst_n, asynchronous, active low) clears the speed, the ramp length and the
// configuration (interval reads as one) and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "stepper_trapezoid_speed_ramp_unit_assert.svh"

module stepper_trapezoid_speed_ramp_unit
    import stsr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stsr_cmd_if.sink   cmd,
    stsr_rsp_if.source rsp,
    stsr_cfg_if.sink   cfg
);

    // Configuration registers. An interval of zero behaves as one everywhere, so it is
    // stored as one.
    logic [SPEED_W-1:0]    start_speed_reg;
    logic [SPEED_W-1:0]    accel_increment_reg;
    logic [INTERVAL_W-1:0] accel_interval_reg;

    // Output register that parts the sequencer from the receiver.
    logic                  rsp_valid_reg;
    rsp_t                  rsp_data_reg;

    ramp_cfg_t             ramp_cfg;
    cmd_t                  cmd_data;
    logic                  cmd_ready;
    logic                  out_free;
    logic                  res_valid;
    rsp_t                  res;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_speed_reg     <= '0;
            accel_increment_reg <= '0;
            accel_interval_reg  <= INTERVAL_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_START_SPEED:
                begin
                    start_speed_reg <= cfg.data;
                end
                CFG_ACCEL_INCREMENT:
                begin
                    accel_increment_reg <= cfg.data;
                end
                CFG_ACCEL_INTERVAL:
                begin
                    accel_interval_reg <= (cfg.data[INTERVAL_W-1:0] == '0) ?
                                          INTERVAL_W'(1) : cfg.data[INTERVAL_W-1:0];
                end
                default:
                begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    assign ramp_cfg.start_speed     = start_speed_reg;
    assign ramp_cfg.accel_increment = accel_increment_reg;
    assign ramp_cfg.accel_interval  = accel_interval_reg;

    assign cmd_data.action      = cmd.action;
    assign cmd_data.set_speed   = cmd.set_speed;
    assign cmd_data.pulse_index = cmd.pulse_index;
    assign cmd_data.pulse_total = cmd.pulse_total;
    assign cmd.ready            = cmd_ready;

    // The sequencer may hand over a result when the output register is empty or is being
    // emptied in this same cycle.
    assign out_free = !rsp_valid_reg || rsp.ready;

    stsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd       (cmd_data),
        .cmd_ready (cmd_ready),
        .cfg       (ramp_cfg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    stsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.speed        = rsp_data_reg.speed;
    assign rsp.start_status = rsp_data_reg.start_status;

    // The sequencer is busy in the cycle after it takes a command.
    `STSR_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready, "cmd still ready after a transaction")
    // A result is never pushed into an occupied output register.
    `STSR_ASSERT_SAME(a_result_slot_free, res_valid, !rsp_valid_reg || rsp.ready, "result overwrote pending response")
    // The shared divider is only started when it is idle.
    `STSR_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")

endmodule

`default_nettype wire

// ===== hw/rtl/stsr_div.sv =====
// Shared restoring divider: 32-bit dividend by 24-bit divisor, one quotient bit per cycle.
// Depends on stsr_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module stsr_div
    import stsr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;

    logic [DIV_D_W:0]     part;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign part = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge   = part >= {1'b0, dvs_reg};
    assign diff = part - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so 24 bits hold it.
            rem_next = ge ? diff[DIV_D_W-1:0] : part[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stsr_ctrl.sv =====
// Sequencer of the speed ramp: classifies each transaction, drives the shared divider
// and keeps the current speed and ramp length. Depends on stsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stsr_ctrl
    import stsr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  wire cmd_t      cmd,
    output logic           cmd_ready,
    input  wire ramp_cfg_t cfg,
    input  wire logic      out_free,
    output logic           res_valid,
    output rsp_t           res,
    output div_req_t       div_req,
    input  wire div_rsp_t  div_rsp
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_CLASS  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_UP    = 2'd1;
    localparam logic [1:0] OP_DOWN  = 2'd2;

    localparam int TRI_W  = PULSE_W + 3;
    localparam int PROD_W = SPEED_W + INTERVAL_W;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    cmd_t               cmd_reg, cmd_next;
    logic               long_reg, long_next;
    logic               status_reg, status_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [PULSE_W-1:0] ramp_reg, ramp_next;

    logic               below_start;
    logic               inc_zero;
    logic [SPEED_W-1:0] span;
    logic               is_long;
    logic [PULSE_W-1:0] remain;
    logic [TRI_W-1:0]   tri_idx;
    logic               short_up;
    logic               short_down;
    logic [SPEED_W:0]   sum_up;
    logic [SPEED_W:0]   floor_dn;
    logic [PROD_W-1:0]  prod;

    assign below_start = cmd_reg.set_speed < cfg.start_speed;
    assign inc_zero    = cfg.accel_increment == '0;
    assign span        = cmd_reg.set_speed - cfg.start_speed;
    assign is_long     = {1'b0, cmd_reg.pulse_total} > {ramp_reg, 1'b0};
    assign remain      = cmd_reg.pulse_total - cmd_reg.pulse_index;
    assign tri_idx     = TRI_W'(cmd_reg.pulse_index) + TRI_W'({cmd_reg.pulse_index, 1'b0});
    // idx < total/3 exactly when 3*(idx+1) <= total; idx > 2*total/3 when 3*idx > 2*total.
    assign short_up    = (tri_idx + TRI_W'(3)) <= TRI_W'(cmd_reg.pulse_total);
    assign short_down  = tri_idx > TRI_W'({cmd_reg.pulse_total, 1'b0});
    assign sum_up      = {1'b0, speed_reg} + {1'b0, cfg.accel_increment};
    assign floor_dn    = {1'b0, cfg.start_speed} + {1'b0, cfg.accel_increment};
    assign prod        = div_rsp.quotient[SPEED_W-1:0] * cfg.accel_interval;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cmd_next         = cmd_reg;
        long_next        = long_reg;
        status_next      = status_reg;
        speed_next       = speed_reg;
        ramp_next        = ramp_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {cmd_reg.pulse_index};
        div_req.divisor  = DIV_D_W'(cfg.accel_interval);
        res_valid        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                status_next = 1'b0;
                long_next   = is_long;
                state_next  = ST_DONE;
                if (cmd_reg.action == ACTION_START)
                begin
                    if (inc_zero)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        speed_next = cfg.start_speed;
                        if (below_start)
                        begin
                            ramp_next = '0;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DIV_N_W'(span);
                            div_req.divisor  = cfg.accel_increment;
                            op_next          = OP_START;
                            state_next       = ST_DIV;
                        end
                    end
                end
                else if (below_start)
                begin
                    speed_next = cfg.start_speed;
                end
                else if (inc_zero)
                begin
                    speed_next = cmd_reg.set_speed;
                end
                else
                begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                state_next = ST_DONE;
                if (long_reg)
                begin
                    if (cmd_reg.pulse_index < ramp_reg)
                    begin
                        if (cmd_reg.pulse_index != '0)
                        begin
                            div_req.start = 1'b1;
                            op_next       = OP_UP;
                            state_next    = ST_DIV;
                        end
                    end
                    else if (remain < ramp_reg)
                    begin
                        div_req.start = 1'b1;
                        op_next       = OP_DOWN;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        speed_next = cmd_reg.set_speed;
                    end
                end
                else if (short_up)
                begin
                    if (cmd_reg.pulse_index != '0)
                    begin
                        div_req.start = 1'b1;
                        op_next       = OP_UP;
                        state_next    = ST_DIV;
                    end
                end
                else if (short_down)
                begin
                    div_req.start = 1'b1;
                    op_next       = OP_DOWN;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                    case (op_reg)
                        OP_START:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_UP:
                        begin
                            if (div_rsp.remainder == '0)
                            begin
                                speed_next = (sum_up > {1'b0, cmd_reg.set_speed}) ?
                                             cmd_reg.set_speed : sum_up[SPEED_W-1:0];
                            end
                        end
                        OP_DOWN:
                        begin
                            if (div_rsp.remainder == '0)
                            begin
                                speed_next = ({1'b0, speed_reg} < floor_dn) ?
                                             cfg.start_speed :
                                             speed_reg - cfg.accel_increment;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                // Ramp length saturates at the full 32-bit range.
                ramp_next  = (prod[PROD_W-1:PULSE_W] != '0) ? '1 : prod[PULSE_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            status_reg <= 1'b0;
            speed_reg  <= '0;
            ramp_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            speed_reg  <= speed_next;
            ramp_reg   <= ramp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cmd_reg  <= cmd_next;
        long_reg <= long_next;
    end

    assign cmd_ready        = state_reg == ST_IDLE;
    assign res.speed        = speed_reg;
    assign res.start_status = status_reg;

endmodule

`default_nettype wire

// ===== sim/stepper_trapezoid_speed_ramp_unit_tb.sv =====
// Self-checking testbench for the stepper trapezoid speed ramp unit.
// Depends on stsr_pkg, the channel interfaces in stsr_if.sv and the unit's top level.
// A scoreboard class predicts each response; directed moves come first, random moves follow.
`timescale 1ns / 1ps

module stepper_trapezoid_speed_ramp_unit_tb
    import stsr_pkg::*;
();

    // Run length and timing knobs.
    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_ITEMS = 2000;
    localparam int SETTLE       = 48;         // a little more than the longest command latency
    localparam int CYCLE_LIMIT  = 2_000_000;  // several times the slowest legal run

    // The short move splits at one third and at two thirds of the total.
    localparam int unsigned SHORT_DIV = 3;
    localparam int unsigned SHORT_MUL = 2;

    // Index 3 is not a register; the unit must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SPEED_W-1:0]   SPEED_MAX  = '1;

    // Scoreboard: a copy of the ramp state and registers that predicts every response.
    class ramp_speed_checker;
        logic [SPEED_W-1:0]    start_speed;
        logic [SPEED_W-1:0]    accel_inc;
        logic [INTERVAL_W-1:0] accel_iv;
        logic [SPEED_W-1:0]    cur_speed;
        logic [PULSE_W-1:0]    ramp_len;
        rsp_t                  pending_speeds[$];
        int                    errors;

        function new();
            start_speed = '0;
            accel_inc   = '0;
            accel_iv    = 1;
            cur_speed   = '0;
            ramp_len    = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPEED_W-1:0] data);
            case (idx)
                CFG_START_SPEED:     start_speed = data;
                CFG_ACCEL_INCREMENT: accel_inc   = data;
                CFG_ACCEL_INTERVAL:  accel_iv    = data[INTERVAL_W-1:0];
                default:             ;
            endcase
        endfunction

        // An interval of zero behaves as an interval of one.
        function logic [INTERVAL_W-1:0] step_interval();
            return (accel_iv == 0) ? INTERVAL_W'(1) : accel_iv;
        endfunction

        function void speed_up(logic [PULSE_W-1:0] idx, logic [SPEED_W-1:0] target);
            logic [SPEED_W:0] sum;
            if (idx != 0 && (idx % step_interval()) == 0)
            begin
                sum = {1'b0, cur_speed} + {1'b0, accel_inc};
                if (sum > {1'b0, target})
                    sum = {1'b0, target};
                cur_speed = sum[SPEED_W-1:0];
            end
        endfunction

        function void slow_down(logic [PULSE_W-1:0] idx);
            if ((idx % step_interval()) == 0)
            begin
                if ({1'b0, cur_speed} < {1'b0, start_speed} + {1'b0, accel_inc})
                    cur_speed = start_speed;
                else
                    cur_speed = cur_speed - accel_inc;
            end
        endfunction

        function void apply_command(cmd_t c);
            rsp_t                          r;
            logic [SPEED_W+INTERVAL_W-1:0] len;
            logic [PULSE_W-1:0]            remaining;
            r.start_status = 1'b0;
            if (c.action == ACTION_START)
            begin
                if (accel_inc == 0)
                    r.start_status = 1'b1;
                else
                begin
                    cur_speed = start_speed;
                    if (c.set_speed < start_speed)
                        ramp_len = '0;
                    else
                    begin
                        len = ((c.set_speed - start_speed) / accel_inc) * step_interval();
                        ramp_len = ((len >> PULSE_W) != 0) ? '1 : len[PULSE_W-1:0];
                    end
                end
            end
            else if (c.set_speed < start_speed)
                cur_speed = start_speed;
            else if (accel_inc == 0)
                cur_speed = c.set_speed;
            else if ({1'b0, c.pulse_total} > {ramp_len, 1'b0})
            begin
                remaining = c.pulse_total - c.pulse_index;
                if (c.pulse_index < ramp_len)
                    speed_up(c.pulse_index, c.set_speed);
                else if (remaining < ramp_len)
                    slow_down(c.pulse_index);
                else
                    cur_speed = c.set_speed;
            end
            else
            begin
                if (c.pulse_index < c.pulse_total / SHORT_DIV)
                    speed_up(c.pulse_index, c.set_speed);
                else if ({2'b0, c.pulse_index} > ({2'b0, c.pulse_total} * SHORT_MUL) / SHORT_DIV)
                    slow_down(c.pulse_index);
            end
            r.speed = cur_speed;
            pending_speeds.push_back(r);
        endfunction

        function void compare_response(logic [SPEED_W-1:0] speed, logic start_status);
            rsp_t r;
            if (pending_speeds.size() == 0)
            begin
                $error("response transaction with no command waiting: speed %0d", speed);
                errors++;
            end
            else
            begin
                r = pending_speeds.pop_front();
                if (speed !== r.speed)
                begin
                    $error("speed mismatch: expected %0d, actual %0d", r.speed, speed);
                    errors++;
                end
                if (start_status !== r.start_status)
                begin
                    $error("start_status mismatch: expected %0d, actual %0d",
                           r.start_status, start_status);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_speeds.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    stsr_cmd_if cmd_ch ();
    stsr_rsp_if rsp_ch ();
    stsr_cfg_if cfg_ch ();

    stepper_trapezoid_speed_ramp_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ramp_speed_checker sb = new();

    int cycle_count = 0;
    int items_sent  = 0;
    bit no_idle     = 1'b0;  // when set, neither side inserts gaps or stalls

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: if the run has not finished by the limit, something hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Gap lengths: mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Response side. The outputs are sampled right after the edge, before the unit's
    // registers update, so each check sees the values that the handshake used. The ready
    // level is then held for a random number of cycles, which spreads the stalls over
    // every phase of the unit's work.
    initial
    begin
        int   hold;
        logic level;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.compare_response(rsp_ch.speed, rsp_ch.start_status);
            if (hold != 0)
                hold--;
            else
            begin
                level = no_idle || ($urandom_range(0, 9) < 7);
                hold = level ? $urandom_range(1, 10) : pick_gap();
                rsp_ch.ready <= level;
            end
        end
    end

    function automatic cmd_t make_cmd(logic action, logic [SPEED_W-1:0] spd,
                                      logic [PULSE_W-1:0] idx, logic [PULSE_W-1:0] tot);
        cmd_t c;
        c.action      = action;
        c.set_speed   = spd;
        c.pulse_index = idx;
        c.pulse_total = tot;
        return c;
    endfunction

    // Sends one command transaction after a random gap. The valid line stays high across
    // back-to-back commands, so it never gets two assignments in one time step.
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= c.action;
        cmd_ch.set_speed   <= c.set_speed;
        cmd_ch.pulse_index <= c.pulse_index;
        cmd_ch.pulse_total <= c.pulse_total;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.apply_command(c);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted response has come back.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Registers change only while the unit is idle: all responses in, then a settle time.
    // The upper data bits of the interval write are random; the unit must drop them.
    task automatic set_phase(input logic [SPEED_W-1:0] s, input logic [SPEED_W-1:0] inc,
                             input logic [INTERVAL_W-1:0] iv);
        drain_results();
        repeat (SETTLE) @(posedge clk);
        write_one(CFG_START_SPEED, s);
        write_one(CFG_ACCEL_INCREMENT, inc);
        write_one(CFG_ACCEL_INTERVAL, {8'($urandom), iv});
        write_one(CFG_UNUSED, SPEED_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Targets mostly sit a whole number of increments above the start speed, so the
    // ramp length stays in a range the pulse walks can cover.
    function automatic logic [SPEED_W-1:0] pick_target();
        logic [SPEED_W+SPEED_W+4:0] t;
        int                         r;
        r = $urandom_range(0, 99);
        if (r < 15 && sb.start_speed != 0)
            t = $urandom_range(0, sb.start_speed - 1);
        else if (r < 25)
            t = SPEED_W'($urandom);
        else if (r < 30)
            t = SPEED_MAX;
        else
        begin
            t = sb.start_speed + sb.accel_inc * $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                t = t + $urandom_range(0, sb.accel_inc);
        end
        return (t > SPEED_MAX) ? SPEED_MAX : t[SPEED_W-1:0];
    endfunction

    // One move: a start, then a walk of consecutive pulses placed around one of the
    // segment borders, with some noise transactions mixed in.
    task automatic run_move();
        logic [SPEED_W-1:0] tgt;
        logic [PULSE_W-1:0] rlen;
        logic [PULSE_W-1:0] total;
        logic [PULSE_W-1:0] base;
        logic [PULSE_W-1:0] stride;
        logic [PULSE_W+1:0] span;
        logic [PULSE_W+1:0] two_thirds;
        int                 n;
        tgt = pick_target();
        send_cmd(make_cmd(ACTION_START, tgt, $urandom, $urandom));
        rlen = sb.ramp_len;
        span = {2'b0, rlen} * 2;
        if ($urandom_range(0, 1) == 1)
        begin
            // Long move: the total exceeds twice the ramp length.
            span = span + 1 + $urandom_range(0, 64);
            total = ((span >> PULSE_W) != 0) ? '1 : span[PULSE_W-1:0];
        end
        else
            total = $urandom_range(0, ((span >> PULSE_W) != 0) ? '1 : span[PULSE_W-1:0]);
        two_thirds = ({2'b0, total} * SHORT_MUL) / SHORT_DIV;
        case ($urandom_range(0, 7))
            0:       base = 0;
            1:       base = rlen - 2;
            2:       base = total - rlen - 2;
            3:       base = total / SHORT_DIV - 2;
            4:       base = two_thirds[PULSE_W-1:0] - 2;
            5:       base = total - 4;
            6:       base = total + $urandom_range(1, 100);
            default: base = $urandom;
        endcase
        stride = ($urandom_range(0, 2) == 0) ? PULSE_W'(sb.step_interval()) : PULSE_W'(1);
        n = $urandom_range(4, 30);
        for (int j = 0; j < n; j++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_cmd(make_cmd(1'($urandom), SPEED_W'($urandom), $urandom, $urandom));
            else
                send_cmd(make_cmd(ACTION_PULSE,
                                  ($urandom_range(0, 15) == 0) ? pick_target() : tgt,
                                  base + j * stride, total));
            // Now and then the sender holds off until the unit has answered everything.
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    // One random phase: new register values, then moves until the phase budget is spent.
    task automatic random_phase();
        logic [SPEED_W-1:0]    s;
        logic [SPEED_W-1:0]    inc;
        logic [INTERVAL_W-1:0] iv;
        int                    r;
        int                    budget;
        int                    first;
        r = $urandom_range(0, 99);
        if (r < 15)
            s = 0;
        else if (r < 20)
            s = SPEED_MAX;
        else if (r < 70)
            s = $urandom_range(0, 5000);
        else
            s = SPEED_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)
            inc = 0;
        else if (r < 20)
            inc = 1;
        else if (r < 25)
            inc = SPEED_MAX;
        else if (r < 75)
            inc = $urandom_range(1, 2000);
        else
            inc = $urandom_range(1, SPEED_MAX);
        r = $urandom_range(0, 99);
        if (r < 40)
            iv = 1;
        else if (r < 70)
            iv = $urandom_range(2, 8);
        else if (r < 85)
            iv = $urandom_range(9, 300);
        else if (r < 95)
            iv = $urandom_range(1, 65535);
        else
            iv = 16'hFFFF;
        set_phase(s, inc, iv);
        // Some phases run with both sides at full rate.
        no_idle = ($urandom_range(0, 4) == 0);
        budget = $urandom_range(40, 120);
        first = items_sent;
        while (items_sent - first < budget)
            run_move();
    endtask

    initial
    begin
        int rand_first;

        rst_n = 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= ACTION_START;
        cmd_ch.set_speed   <= '0;
        cmd_ch.pulse_index <= '0;
        cmd_ch.pulse_total <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_START_SPEED;
        cfg_ch.data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Registers as reset leaves them: a zero increment rejects the start, and a
        // pulse then jumps straight to the target. Index and total at all ones.
        send_cmd(make_cmd(ACTION_START, 24'd500, '0, '0));
        send_cmd(make_cmd(ACTION_PULSE, 24'd777, '0, '0));
        send_cmd(make_cmd(ACTION_PULSE, SPEED_MAX, '1, '1));

        // Start speed 100, increment 10, interval 2: a target of 200 gives a ramp of
        // 20 pulses. First a target below the start speed, at start and on a pulse.
        set_phase(24'd100, 24'd10, 16'd2);
        send_cmd(make_cmd(ACTION_START, 24'd50, 32'd0, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd50, 32'd3, 32'd100));
        // Long move of 100 pulses: ramp up, plateau, ramp down, and an index past the
        // total, where the remaining count wraps and the pulse lands on the plateau.
        send_cmd(make_cmd(ACTION_START, 24'd200, 32'd0, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd0, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd2, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd4, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd20, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd50, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd82, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd150, 32'd100));
        // Short move of 30 pulses: up in the first third, hold, down after two thirds.
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd4, 32'd30));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd15, 32'd30));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd24, 32'd30));
        // Deceleration that would drop below the start speed saturates there.
        send_cmd(make_cmd(ACTION_START, 24'd200, 32'd0, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd2, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd98, 32'd100));
        send_cmd(make_cmd(ACTION_PULSE, 24'd200, 32'd98, 32'd100));

        // Increment 1 with the longest interval overflows the ramp length, which then
        // saturates; twice that length must be compared without wrapping.
        set_phase('0, 24'd1, 16'hFFFF);
        send_cmd(make_cmd(ACTION_START, SPEED_MAX, '0, '0));
        send_cmd(make_cmd(ACTION_PULSE, SPEED_MAX, 32'd65535, '1));
        send_cmd(make_cmd(ACTION_PULSE, '0, '0, '0));

        // Start speed and increment both at their maximum.
        set_phase(SPEED_MAX, SPEED_MAX, 16'd1);
        send_cmd(make_cmd(ACTION_START, SPEED_MAX, '0, '0));
        send_cmd(make_cmd(ACTION_PULSE, SPEED_MAX, 32'd5, 32'd10));

        rand_first = items_sent;
        while (items_sent - rand_first < RANDOM_ITEMS)
            random_phase();

        // Wait for the last responses, then a little longer to catch any extra one.
        no_idle = 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/stsr_pkg.sv
hw/rtl/stsr_if.sv
hw/rtl/stsr_div.sv
hw/rtl/stsr_ctrl.sv
hw/rtl/stepper_trapezoid_speed_ramp_unit.sv
sim/stepper_trapezoid_speed_ramp_unit_tb.sv
